// ===== hw/rtl/rtttl_note_parser_macros.svh =====
// ----------------------------------------------------------------------------
// rtttl note parser assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RTTTL_NOTE_PARSER_MACROS_SVH
`define RTTTL_NOTE_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define RNP_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtttl_note_parser: check failed");
// next-cycle implication
`define RNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtttl_note_parser: check failed");
`else
`define RNP_ASSERT(label, clk, rst_n, ante, cons)
`define RNP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/rnp_pkg.sv =====
// ----------------------------------------------------------------------------
// rnp_pkg
// shared widths, codes, character constants and record types
// ----------------------------------------------------------------------------
`default_nettype none

package rnp_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned DUR_W     = 20;
	localparam int unsigned DIV_W     = 8;
	localparam int unsigned OCT_W     = 3;
	localparam int unsigned BPM_W     = 10;
	localparam int unsigned WHOLE_W   = 18;
	localparam int unsigned CFG_W     = 10;
	localparam int unsigned REG_IDX_W = 2;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned DOTS_W    = 2;
	localparam int unsigned SEMI_W    = 4;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_FALLBACK_DURATION = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FALLBACK_OCTAVE   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FALLBACK_BPM      = 2'd2;

	localparam logic [DIV_W-1:0] RST_FALLBACK_DURATION = 8'd4;
	localparam logic [OCT_W-1:0] RST_FALLBACK_OCTAVE   = 3'd6;
	localparam logic [BPM_W-1:0] RST_FALLBACK_BPM      = 10'd63;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_REST       = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TONE       = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END        = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD_OCTAVE = 2'd3;

	// queue record operations
	localparam logic [OP_W-1:0] OP_TEMPO = 2'd0;
	localparam logic [OP_W-1:0] OP_NOTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_END   = 2'd2;

	localparam logic [WHOLE_W-1:0] MS_PER_MINUTE = 18'd60000;

	// characters
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_SHARP = 8'h23;
	localparam logic [CH_W-1:0] CH_UNDER = 8'h5f;
	localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CH_W-1:0] CH_COLON = 8'h3a;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_FOUR  = 8'h34;
	localparam logic [CH_W-1:0] CH_SEVEN = 8'h37;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_A     = 8'h61;
	localparam logic [CH_W-1:0] CH_B     = 8'h62;
	localparam logic [CH_W-1:0] CH_C     = 8'h63;
	localparam logic [CH_W-1:0] CH_D     = 8'h64;
	localparam logic [CH_W-1:0] CH_E     = 8'h65;
	localparam logic [CH_W-1:0] CH_F     = 8'h66;
	localparam logic [CH_W-1:0] CH_G     = 8'h67;
	localparam logic [CH_W-1:0] CH_H     = 8'h68;
	localparam logic [CH_W-1:0] CH_O     = 8'h6f;

	typedef struct packed {
		logic [DIV_W-1:0] duration;
		logic [OCT_W-1:0] octave;
		logic [BPM_W-1:0] bpm;
	} cfg_t;

	// arg holds the bpm for a tempo record, the divisor for a note
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic [BPM_W-1:0]  arg;
		logic [DOTS_W-1:0] dots;
	} rec_t;

	function automatic logic [SEMI_W-1:0] semitone_of(input logic [CH_W-1:0] c);
		logic [SEMI_W-1:0] s;
		case (c)
			CH_C:       s = 4'd1;
			CH_D:       s = 4'd3;
			CH_E:       s = 4'd5;
			CH_F:       s = 4'd6;
			CH_G:       s = 4'd8;
			CH_A:       s = 4'd10;
			CH_B, CH_H: s = 4'd12;
			default:    s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rnp_char_if.sv =====
// ----------------------------------------------------------------------------
// rnp_char_if
// character channel, one byte per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface rnp_char_if;
	logic                     valid;
	logic                     ready;
	logic [rnp_pkg::CH_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rnp_note_if.sv =====
// ----------------------------------------------------------------------------
// rnp_note_if
// note result channel, one record per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface rnp_note_if;
	logic                       valid;
	logic                       ready;
	logic [rnp_pkg::KIND_W-1:0] kind;
	logic [rnp_pkg::IDX_W-1:0]  note_index;
	logic [rnp_pkg::DUR_W-1:0]  duration_ms;

	modport source (output valid, output kind, output note_index, output duration_ms,
		input ready);
	modport sink (input valid, input kind, input note_index, input duration_ms,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rtttl_note_parser.sv =====
// ----------------------------------------------------------------------------
// rtttl_note_parser
// ringtone text parser: header defaults, note decode, note length in ms
// ----------------------------------------------------------------------------
// characters are taken one per cycle while the record queue has room
// a note beat follows its closing character through the queue, the 18-step
// divider, a dot step per dot and the output register; an end beat skips
// the divider; the timing unit takes a new record only when idle, so back
// to back notes and tempo changes are each paced by the divider
// reset: parser in title phase, fallbacks 4 / 6 / 63, queue and output empty
`default_nettype none

module rtttl_note_parser #(
	parameter int unsigned QUEUE_DEPTH = rnp_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rnp_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [rnp_pkg::CFG_W-1:0]     wr_data,
	rnp_char_if.sink                      chars,
	rnp_note_if.source                    notes
);

	rnp_pkg::cfg_t cfg_q;
	rnp_pkg::rec_t front_rec;
	rnp_pkg::rec_t back_rec;
	logic          front_valid;
	logic          front_ready;
	logic          back_valid;
	logic          back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duration <= rnp_pkg::RST_FALLBACK_DURATION;
			cfg_q.octave   <= rnp_pkg::RST_FALLBACK_OCTAVE;
			cfg_q.bpm      <= rnp_pkg::RST_FALLBACK_BPM;
		end else if (wr_en) begin
			case (wr_index)
				rnp_pkg::REG_FALLBACK_DURATION: cfg_q.duration <= wr_data[7:0];
				rnp_pkg::REG_FALLBACK_OCTAVE:   cfg_q.octave   <= wr_data[2:0];
				rnp_pkg::REG_FALLBACK_BPM:      cfg_q.bpm      <= wr_data[9:0];
				default: begin
				end
			endcase
		end
	end

	rnp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.chars     (chars),
		.rec_valid (front_valid),
		.rec_ready (front_ready),
		.rec       (front_rec)
	);

	rnp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_rec    (front_rec),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_rec   (back_rec)
	);

	rnp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (back_valid),
		.in_ready (back_ready),
		.in_rec   (back_rec),
		.notes    (notes)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/rnp_front.sv =====
// ----------------------------------------------------------------------------
// rnp_front
// character parser: title, header fields and note syntax; while the record queue has room, one char per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  rnp_pkg::cfg_t   cfg,
	rnp_char_if.sink        chars,
	output logic            rec_valid,
	input  logic            rec_ready,
	output rnp_pkg::rec_t   rec
);

	`include "rtttl_note_parser_macros.svh"

	localparam logic [2:0] PH_TITLE = 3'd0;
	localparam logic [2:0] PH_HDR   = 3'd1;
	localparam logic [2:0] PH_EQ    = 3'd2;
	localparam logic [2:0] PH_VAL   = 3'd3;
	localparam logic [2:0] PH_OSKIP = 3'd4;
	localparam logic [2:0] PH_NDUR  = 3'd5;
	localparam logic [2:0] PH_NMOD  = 3'd6;

	localparam logic [1:0] HDR_DUR = 2'd0;
	localparam logic [1:0] HDR_OCT = 2'd1;
	localparam logic [1:0] HDR_BPM = 2'd2;

	localparam logic [2:0] STG_SHARP = 3'd0;
	localparam logic [2:0] STG_DOT1  = 3'd1;
	localparam logic [2:0] STG_OCT   = 3'd2;
	localparam logic [2:0] STG_DOT2  = 3'd3;
	localparam logic [2:0] STG_DONE  = 3'd4;

	logic [2:0]                   phase_q, phase_d;
	logic [1:0]                   hdr_q, hdr_d;
	logic [rnp_pkg::BPM_W-1:0]    accum_q, accum_d;
	logic [rnp_pkg::DIV_W-1:0]    ndiv_q, ndiv_d;
	logic [rnp_pkg::SEMI_W-1:0]   semi_q, semi_d;
	logic [rnp_pkg::DOTS_W-1:0]   dots_q, dots_d;
	logic [3:0]                   noct_q, noct_d;
	logic [2:0]                   stage_q, stage_d;
	logic                         pend_q, pend_d;
	logic [rnp_pkg::DIV_W-1:0]    sdur_q, sdur_d;
	logic [rnp_pkg::OCT_W-1:0]    soct_q, soct_d;

	logic                         accept;
	logic [rnp_pkg::CH_W-1:0]     c;
	logic                         is_dig;
	logic [3:0]                   dval;
	logic [13:0]                  accum_mul;
	logic [rnp_pkg::BPM_W-1:0]    accum_sat;
	logic                         do_clear;
	logic                         do_start;
	logic [rnp_pkg::DIV_W-1:0]    start_base;
	logic [11:0]                  ndiv_mul;

	function automatic rnp_pkg::rec_t mk_note(
		input logic [rnp_pkg::SEMI_W-1:0] semi,
		input logic [3:0]                 oct,
		input logic [rnp_pkg::DIV_W-1:0]  ndiv,
		input logic [rnp_pkg::DIV_W-1:0]  sdur,
		input logic [rnp_pkg::DOTS_W-1:0] dots
	);
		rnp_pkg::rec_t             r;
		logic [rnp_pkg::IDX_W-1:0] idx;
		logic [rnp_pkg::DIV_W-1:0] dv;
		idx = 6'(oct - 4'd4) * 6'd12 + 6'(semi);
		if (ndiv != '0) begin
			dv = ndiv;
		end else if (sdur != '0) begin
			dv = sdur;
		end else begin
			dv = 8'd1;
		end
		r      = '0;
		r.op   = rnp_pkg::OP_NOTE;
		r.arg  = 10'(dv);
		r.dots = dots;
		if (semi == '0) begin
			r.kind = rnp_pkg::KIND_REST;
		end else if (oct < 4'd4 || oct > 4'd7 || idx > 6'd48) begin
			r.kind = rnp_pkg::KIND_BAD_OCTAVE;
		end else begin
			r.kind = rnp_pkg::KIND_TONE;
			r.idx  = idx;
		end
		return r;
	endfunction

	function automatic logic [rnp_pkg::BPM_W-1:0] resolve_bpm(
		input logic [rnp_pkg::BPM_W-1:0] bpm,
		input logic [rnp_pkg::BPM_W-1:0] fb
	);
		logic [rnp_pkg::BPM_W-1:0] b;
		if (bpm != '0) begin
			b = bpm;
		end else if (fb != '0) begin
			b = fb;
		end else begin
			b = 10'd1;
		end
		return b;
	endfunction

	assign accept      = chars.valid && chars.ready;
	assign chars.ready = rec_ready;
	assign c           = chars.ch;
	assign is_dig      = (c >= rnp_pkg::CH_ZERO) && (c <= rnp_pkg::CH_NINE);
	assign dval        = c[3:0];
	assign accum_mul   = 14'(accum_q) * 14'd10 + 14'(dval);
	assign accum_sat   = (accum_mul > 14'd1023) ? 10'd1023 : accum_mul[9:0];
	assign start_base  = do_clear ? '0 : ndiv_q;
	assign ndiv_mul    = 12'(start_base) * 12'd10 + 12'(dval);

	always_comb begin
		phase_d   = phase_q;
		hdr_d     = hdr_q;
		accum_d   = accum_q;
		ndiv_d    = ndiv_q;
		semi_d    = semi_q;
		dots_d    = dots_q;
		noct_d    = noct_q;
		stage_d   = stage_q;
		pend_d    = pend_q;
		sdur_d    = sdur_q;
		soct_d    = soct_q;
		rec_valid = 1'b0;
		rec       = '0;
		do_clear  = 1'b0;
		do_start  = 1'b0;
		if (accept) begin
			if (c == rnp_pkg::CH_NUL) begin
				rec_valid = 1'b1;
				do_clear  = 1'b1;
				if (phase_q == PH_NMOD) begin
					rec = mk_note(semi_q, (stage_q <= STG_OCT) ? {1'b0, soct_q} : noct_q,
						ndiv_q, sdur_q, dots_q);
					phase_d = PH_NDUR;
				end else if (phase_q == PH_NDUR && pend_q) begin
					rec = mk_note('0, {1'b0, soct_q}, ndiv_q, sdur_q, dots_q);
					phase_d = PH_NDUR;
				end else begin
					rec.op  = rnp_pkg::OP_END;
					phase_d = PH_TITLE;
				end
			end else begin
				case (phase_q)
					PH_TITLE: begin
						if (c == rnp_pkg::CH_COLON) begin
							sdur_d  = cfg.duration;
							soct_d  = cfg.octave;
							hdr_d   = HDR_DUR;
							phase_d = PH_HDR;
						end
					end
					PH_HDR: begin
						if (hdr_q == HDR_DUR && c == rnp_pkg::CH_D) begin
							hdr_d   = HDR_DUR;
							phase_d = PH_EQ;
						end else if (hdr_q <= HDR_OCT && c == rnp_pkg::CH_O) begin
							hdr_d   = HDR_OCT;
							phase_d = PH_EQ;
						end else if (hdr_q <= HDR_BPM && c == rnp_pkg::CH_B) begin
							hdr_d   = HDR_BPM;
							phase_d = PH_EQ;
						end else begin
							rec_valid = 1'b1;
							rec.op    = rnp_pkg::OP_TEMPO;
							rec.arg   = resolve_bpm('0, cfg.bpm);
							do_clear  = 1'b1;
							do_start  = 1'b1;
							phase_d   = PH_NDUR;
						end
					end
					PH_EQ: begin
						accum_d = '0;
						phase_d = PH_VAL;
					end
					PH_VAL: begin
						if (hdr_q == HDR_OCT) begin
							soct_d = (c >= rnp_pkg::CH_FOUR && c <= rnp_pkg::CH_SEVEN) ?
								c[2:0] : cfg.octave;
							phase_d = PH_OSKIP;
						end else if (is_dig) begin
							accum_d = accum_sat;
						end else if (hdr_q == HDR_DUR) begin
							if (accum_q == '0) begin
								sdur_d = cfg.duration;
							end else if (accum_q > 10'd255) begin
								sdur_d = 8'd255;
							end else begin
								sdur_d = accum_q[7:0];
							end
							hdr_d   = HDR_OCT;
							phase_d = PH_HDR;
						end else begin
							rec_valid = 1'b1;
							rec.op    = rnp_pkg::OP_TEMPO;
							rec.arg   = resolve_bpm((accum_q > 10'd999) ? 10'd999 : accum_q,
								cfg.bpm);
							do_clear  = 1'b1;
							phase_d   = PH_NDUR;
						end
					end
					PH_OSKIP: begin
						hdr_d   = HDR_BPM;
						phase_d = PH_HDR;
					end
					PH_NDUR: begin
						do_start = 1'b1;
					end
					PH_NMOD: begin
						if (stage_q == STG_SHARP &&
							(c == rnp_pkg::CH_SHARP || c == rnp_pkg::CH_UNDER)) begin
							semi_d  = semi_q + 4'd1;
							stage_d = STG_DOT1;
						end else if (stage_q <= STG_DOT1 && c == rnp_pkg::CH_DOT) begin
							dots_d  = dots_q + 2'd1;
							stage_d = STG_OCT;
						end else if (stage_q <= STG_OCT && is_dig) begin
							noct_d  = dval;
							stage_d = STG_DOT2;
						end else if (stage_q <= STG_DOT2 && c == rnp_pkg::CH_DOT) begin
							dots_d  = dots_q + 2'd1;
							stage_d = STG_DONE;
							if (stage_q <= STG_OCT) begin
								noct_d = {1'b0, soct_q};
							end
						end else begin
							rec_valid = 1'b1;
							rec = mk_note(semi_q,
								(stage_q <= STG_OCT) ? {1'b0, soct_q} : noct_q,
								ndiv_q, sdur_q, dots_q);
							do_clear = 1'b1;
							do_start = (c != rnp_pkg::CH_COMMA);
							phase_d  = PH_NDUR;
						end
					end
					default: begin
						phase_d = PH_TITLE;
					end
				endcase
			end
		end
		if (do_clear) begin
			ndiv_d  = '0;
			semi_d  = '0;
			dots_d  = '0;
			noct_d  = '0;
			pend_d  = 1'b0;
			stage_d = STG_SHARP;
		end
		if (do_start) begin
			pend_d = 1'b1;
			if (is_dig) begin
				ndiv_d = (ndiv_mul > 12'd255) ? 8'd255 : ndiv_mul[7:0];
			end else begin
				semi_d  = rnp_pkg::semitone_of(c);
				stage_d = STG_SHARP;
				phase_d = PH_NMOD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TITLE;
			hdr_q   <= HDR_DUR;
			accum_q <= '0;
			ndiv_q  <= '0;
			semi_q  <= '0;
			dots_q  <= '0;
			noct_q  <= '0;
			stage_q <= STG_SHARP;
			pend_q  <= 1'b0;
			sdur_q  <= rnp_pkg::RST_FALLBACK_DURATION;
			soct_q  <= rnp_pkg::RST_FALLBACK_OCTAVE;
		end else begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			accum_q <= accum_d;
			ndiv_q  <= ndiv_d;
			semi_q  <= semi_d;
			dots_q  <= dots_d;
			noct_q  <= noct_d;
			stage_q <= stage_d;
			pend_q  <= pend_d;
			sdur_q  <= sdur_d;
			soct_q  <= soct_d;
		end
	end

	`RNP_ASSERT(a_nmod_pending, clk, arst_n, phase_q == PH_NMOD, pend_q)
	`RNP_ASSERT(a_note_div, clk, arst_n, rec_valid && rec.op == rnp_pkg::OP_NOTE, rec.arg != '0)

endmodule

`default_nettype wire

// ===== hw/rtl/rnp_queue.sv =====
// ----------------------------------------------------------------------------
// rnp_queue
// small record fifo between the parser and the timing unit
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_queue #(
	parameter int unsigned DEPTH = rnp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rnp_pkg::rec_t in_rec,
	output logic          out_valid,
	input  logic          out_ready,
	output rnp_pkg::rec_t out_rec
);

	`include "rtttl_note_parser_macros.svh"

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rnp_pkg::rec_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = (cnt_q != CNT_W'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_rec   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`RNP_ASSERT(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`RNP_ASSERT_NEXT(a_push_visible, clk, arst_n, push && !pop, out_valid)

endmodule

`default_nettype wire

// ===== hw/rtl/rnp_back.sv =====
// ----------------------------------------------------------------------------
// rnp_back
// timing unit: shared restoring divider for tempo and note length, dots,
// registered result beat
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rnp_pkg::rec_t in_rec,
	rnp_note_if.source    notes
);

	`include "rtttl_note_parser_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DOT  = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	localparam int unsigned NUM_W = rnp_pkg::WHOLE_W;
	localparam int unsigned CNT_W = $clog2(NUM_W);
	localparam int unsigned DEN_W = rnp_pkg::BPM_W;

	logic [1:0]                  state_q;
	logic [NUM_W-1:0]            num_q;
	logic [DEN_W-1:0]            rem_q;
	logic [DEN_W-1:0]            den_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        tempo_q;
	logic [rnp_pkg::KIND_W-1:0]  kind_q;
	logic [rnp_pkg::IDX_W-1:0]   idx_q;
	logic [rnp_pkg::DOTS_W-1:0]  dots_q;
	logic [rnp_pkg::DUR_W-1:0]   dur_q;
	logic [rnp_pkg::WHOLE_W-1:0] whole_q;
	logic                        ovalid_q;
	logic [rnp_pkg::KIND_W-1:0]  okind_q;
	logic [rnp_pkg::IDX_W-1:0]   oidx_q;
	logic [rnp_pkg::DUR_W-1:0]   odur_q;

	logic [DEN_W:0]              trial;
	logic                        ge;
	logic [DEN_W-1:0]            rem_n;
	logic [NUM_W-1:0]            num_n;
	logic                        pop;
	logic                        load;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign rem_n = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
	assign num_n = {num_q[NUM_W-2:0], ge};

	assign in_ready = (state_q == ST_IDLE);
	assign pop      = in_valid && in_ready;
	assign load     = (state_q == ST_LOAD) && (!ovalid_q || notes.ready);

	assign notes.valid       = ovalid_q;
	assign notes.kind        = okind_q;
	assign notes.note_index  = oidx_q;
	assign notes.duration_ms = odur_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			dots_q <= in_rec.dots;
			den_q  <= in_rec.arg;
			rem_q  <= '0;
			cnt_q  <= '0;
			dur_q  <= '0;
			if (in_rec.op == rnp_pkg::OP_TEMPO) begin
				num_q <= rnp_pkg::MS_PER_MINUTE;
			end else begin
				num_q <= whole_q;
			end
			if (in_rec.op == rnp_pkg::OP_END) begin
				kind_q <= rnp_pkg::KIND_END;
				idx_q  <= '0;
			end else begin
				kind_q <= in_rec.kind;
				idx_q  <= in_rec.idx;
			end
		end else if (state_q == ST_DIV) begin
			num_q <= num_n;
			rem_q <= rem_n;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				dur_q <= rnp_pkg::DUR_W'(num_n);
			end
		end else if (state_q == ST_DOT) begin
			dur_q  <= dur_q + (dur_q >> 1);
			dots_q <= dots_q - 1'b1;
		end
		if (load) begin
			okind_q <= kind_q;
			oidx_q  <= idx_q;
			odur_q  <= dur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tempo_q  <= 1'b0;
			whole_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						tempo_q <= (in_rec.op == rnp_pkg::OP_TEMPO);
						if (in_rec.op == rnp_pkg::OP_END) begin
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						if (tempo_q) begin
							whole_q <= {num_n[NUM_W-3:0], 2'b00};
							state_q <= ST_IDLE;
						end else if (dots_q != '0) begin
							state_q <= ST_DOT;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DOT: begin
					if (dots_q == 2'd1) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (notes.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	`RNP_ASSERT(a_div_den, clk, arst_n, state_q == ST_DIV, den_q != '0)
	`RNP_ASSERT(a_end_beat, clk, arst_n, ovalid_q && okind_q == rnp_pkg::KIND_END,
		oidx_q == '0 && odur_q == '0)

endmodule

`default_nettype wire
